[rtl/lea_pkg.sv]
package lea_pkg;

	typedef struct packed {
		logic        req_type;
		logic [63:0] data_low;
		logic [63:0] data_high;
	} lea_in_t;

	typedef struct packed {
		logic [63:0] result_low;
		logic [63:0] result_high;
	} lea_out_t;

	typedef enum logic [2:0] {
		REG_KEY_SIZE = 3'd0,
		REG_KEY_01   = 3'd1,
		REG_KEY_23   = 3'd2,
		REG_KEY_45   = 3'd3,
		REG_KEY_67   = 3'd4
	} lea_reg_t;

	typedef enum logic [1:0] {
		KS_128 = 2'd0,
		KS_192 = 2'd1,
		KS_256 = 2'd2
	} lea_ks_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_ROUND,
		ST_OUT
	} lea_state_t;

	typedef struct packed {
		logic       exp_start;
		logic       exp_step;
		logic       load;
		logic       round;
		logic [4:0] rnd;
	} lea_cmd_t;

	typedef logic [31:0] word_t;

	localparam word_t DELTA [8] = '{
		32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
		32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
	};

	function automatic word_t rotl(input word_t v, input logic [4:0] n);
		logic [63:0] d;
		d = {v, v} << n;
		return d[63:32];
	endfunction

	function automatic logic [5:0] nrounds(input logic [1:0] ks);
		unique case (ks)
			KS_128:  return 6'd24;
			KS_192:  return 6'd28;
			default: return 6'd32;
		endcase
	endfunction

endpackage

[rtl/lea_ctrl.sv]
module lea_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              sched_ok,
	input  logic [1:0]        key_size,
	output lea_pkg::lea_cmd_t cmd,
	output logic              sched_done
);
	import lea_pkg::*;

	lea_state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic [5:0] nr;

	assign nr = nrounds(key_size);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = sched_ok ? ST_LOAD : ST_EXPAND;
			ST_EXPAND: if ({1'b0, cnt_q} == nr - 6'd1) state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_ROUND;
			ST_ROUND:  if ({1'b0, cnt_q} == nr - 6'd1) state_d = ST_OUT;
			ST_OUT:    if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rnd = cnt_q;
		sched_done = 1'b0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE:   cmd.exp_start = in_valid && !sched_ok;
			ST_EXPAND: begin
				cmd.exp_step = 1'b1;
				sched_done = ({1'b0, cnt_q} == nr - 6'd1);
			end
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = 1'b1;
			end
			ST_ROUND:  cmd.round = 1'b1;
			ST_OUT:    out_valid = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) cnt_q <= '0;
			else cnt_q <= cnt_q + 5'd1;
		end
	end
endmodule

[rtl/lea_dp.sv]
module lea_dp (
	input  logic              clk,
	input  lea_pkg::lea_cmd_t cmd,
	input  logic [1:0]        key_size,
	input  logic [255:0]      key,
	input  lea_pkg::lea_in_t  in_data,
	output lea_pkg::lea_out_t out_data
);
	import lea_pkg::*;

	// Six round-key words are stored per round in one wide memory row.
	logic [191:0] rk_mem [32];
	logic [191:0] rk_rd;
	word_t t_q [8];
	word_t t_d [8];
	word_t rk_w [6];
	word_t x_q [4];
	logic dec_q;
	logic [5:0] nr;
	logic [4:0] rd_addr;
	logic [4:0] rnd_next;
	word_t d;

	assign nr = nrounds(key_size);

	always_comb begin
		logic [2:0] k;
		logic [4:0] sh;
		t_d = t_q;
		unique case (key_size)
			KS_128: d = DELTA[{1'b0, cmd.rnd[1:0]}];
			// The quotient by six is a multiply by 43 and a shift, exact below 32.
			KS_192: d = DELTA[3'(cmd.rnd - 5'd6 * 5'((11'(cmd.rnd) * 11'd43) >> 8))];
			default: d = DELTA[cmd.rnd[2:0]];
		endcase
		for (int j = 0; j < 6; j++) begin
			sh = cmd.rnd + 5'(j);
			if (key_size == KS_128) k = 3'(j);
			else if (key_size == KS_192) k = 3'(j);
			else k = 3'(6 * cmd.rnd + 5'(j));
			if (j < 4 || key_size != KS_128) begin
				unique case (j)
					0: t_d[k] = rotl(t_q[k] + rotl(d, sh), 5'd1);
					1: t_d[k] = rotl(t_q[k] + rotl(d, sh), 5'd3);
					2: t_d[k] = rotl(t_q[k] + rotl(d, sh), 5'd6);
					3: t_d[k] = rotl(t_q[k] + rotl(d, sh), 5'd11);
					4: t_d[k] = rotl(t_q[k] + rotl(d, sh), 5'd13);
					default: t_d[k] = rotl(t_q[k] + rotl(d, sh), 5'd17);
				endcase
				rk_w[j] = t_d[k];
			end else begin
				rk_w[j] = '0;
			end
		end
		if (key_size == KS_128) begin
			rk_w[3] = t_d[1];
			rk_w[4] = t_d[3];
			rk_w[5] = t_d[1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_start) begin
			for (int i = 0; i < 8; i++) t_q[i] <= key[32*i +: 32];
		end else if (cmd.exp_step) begin
			t_q <= t_d;
			rk_mem[cmd.rnd] <= {rk_w[5], rk_w[4], rk_w[3], rk_w[2], rk_w[1], rk_w[0]};
		end
	end

	// Read address leads the round counter by one so the registered row is ready.
	always_comb begin
		logic dec;
		dec = cmd.load ? in_data.req_type : dec_q;
		rnd_next = cmd.load ? 5'd0 : cmd.rnd + 5'd1;
		rd_addr = dec ? 5'(nr - 6'd1 - {1'b0, rnd_next}) : rnd_next;
	end

	always_ff @(posedge clk) begin
		rk_rd <= rk_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		word_t k [6];
		word_t n0, n1, n2, n3;
		for (int i = 0; i < 6; i++) k[i] = rk_rd[32*i +: 32];
		if (cmd.load) begin
			dec_q <= in_data.req_type;
			x_q[0] <= in_data.data_low[31:0];
			x_q[1] <= in_data.data_low[63:32];
			x_q[2] <= in_data.data_high[31:0];
			x_q[3] <= in_data.data_high[63:32];
		end else if (cmd.round) begin
			if (!dec_q) begin
				x_q[0] <= rotl((x_q[0] ^ k[0]) + (x_q[1] ^ k[1]), 5'd9);
				x_q[1] <= rotl((x_q[1] ^ k[2]) + (x_q[2] ^ k[3]), 5'd27);
				x_q[2] <= rotl((x_q[2] ^ k[4]) + (x_q[3] ^ k[5]), 5'd29);
				x_q[3] <= x_q[0];
			end else begin
				n0 = x_q[3];
				n1 = (rotl(x_q[0], 5'd23) - (n0 ^ k[0])) ^ k[1];
				n2 = (rotl(x_q[1], 5'd5) - (n1 ^ k[2])) ^ k[3];
				n3 = (rotl(x_q[2], 5'd3) - (n2 ^ k[4])) ^ k[5];
				x_q[0] <= n0;
				x_q[1] <= n1;
				x_q[2] <= n2;
				x_q[3] <= n3;
			end
		end
	end

	assign out_data.result_low  = {x_q[1], x_q[0]};
	assign out_data.result_high = {x_q[3], x_q[2]};
endmodule

[rtl/lea_block_cipher.sv]
// Channel  Handshake              Payload
// cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
// in       in_valid/in_ready      in_data (lea_in_t)
// out      out_valid/out_ready    out_data (lea_out_t)
// One block runs 24, 28 or 32 rounds of the round unit, between a load state and an output state.
// After reset or a register write the first block first runs the key expansion,
// one round's six keys a cycle. The result is held until taken.
// Reset clears the key registers and marks the schedule stale.
module lea_block_cipher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  lea_pkg::lea_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output lea_pkg::lea_out_t out_data
);
	import lea_pkg::*;

	logic [1:0] key_size_q;
	logic [255:0] key_q;
	logic sched_ok_q;
	logic sched_done;
	lea_cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= '0;
			key_q <= '0;
			sched_ok_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_KEY_SIZE: key_size_q <= (cfg_data[1:0] == 2'd3) ? KS_256 : cfg_data[1:0];
					REG_KEY_01:   key_q[63:0] <= cfg_data;
					REG_KEY_23:   key_q[127:64] <= cfg_data;
					REG_KEY_45:   key_q[191:128] <= cfg_data;
					REG_KEY_67:   key_q[255:192] <= cfg_data;
					default: ;
				endcase
			end
			if (cfg_valid && cfg_index <= REG_KEY_67) sched_ok_q <= 1'b0;
			else if (sched_done) sched_ok_q <= 1'b1;
		end
	end

	lea_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sched_ok(sched_ok_q),
		.key_size(key_size_q), .cmd(cmd), .sched_done(sched_done)
	);

	lea_dp u_dp (
		.clk(clk), .cmd(cmd), .key_size(key_size_q), .key(key_q),
		.in_data(in_data), .out_data(out_data)
	);
endmodule
